// ===== design/fbc_pkg.sv =====
// Shared constants, types and helper functions of the 48-bit Feistel block cipher.
`default_nettype none
package fbc_pkg;

   // Default geometry
   localparam int ROUNDS_DEF      = 254;
   localparam int PERM_TABLES_DEF = 16;

   // Fixed table geometry
   localparam int TBL_W       = 4;
   localparam int PERM_DEPTH  = 4096;
   localparam int BYTE_DEPTH  = 256;
   localparam int HALF_W      = 24;
   localparam int BLOCK_W     = 48;
   localparam int SEL_W       = 18;
   localparam int ROT_W       = 5;
   localparam logic [SEL_W-1:0] SEL_RESET = 18'h24924;

   // index / 3 as (index * 683) >> 11, exact for indexes below 1024
   localparam int KEY_RECIP = 683;
   localparam int KEY_SHIFT = 11;

   // Opcodes
   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_ENC  = 2'd1,
      OP_DEC  = 2'd2,
      OP_NONE = 2'd3
   } fbc_op_type;

   // Table selects
   localparam logic [2:0] TS_PERM = 3'd0;
   localparam logic [2:0] TS_MIX  = 3'd1;
   localparam logic [2:0] TS_SBOX = 3'd2;
   localparam logic [2:0] TS_ISBX = 3'd3;
   localparam logic [2:0] TS_KEY1 = 3'd4;
   localparam logic [2:0] TS_KEY2 = 3'd5;
   localparam logic [2:0] TS_ROT  = 3'd6;

   // Round phases (one-hot bit positions)
   localparam int PHASES   = 5;
   localparam int PH_KEY   = 0;
   localparam int PH_SBOX  = 1;
   localparam int PH_SUBST = 2;
   localparam int PH_MIX   = 3;
   localparam int PH_FOLD  = 4;

   // Half block, byte 0 most significant
   typedef logic [0:2][7:0] fbc_half_type;

   // Controller to datapath commands
   typedef struct packed {
      logic              load;
      logic              start;
      logic              decrypt;
      logic              step;
      logic              last;
      logic [PHASES-1:0] phase;
   } fbc_cmd_type;

   // Rotation amount modulo 24
   function automatic logic [ROT_W-1:0] rot_amt(input logic [ROT_W-1:0] a);
      rot_amt = (a >= ROT_W'(HALF_W)) ? ROT_W'(a - ROT_W'(HALF_W)) : a;
   endfunction

   function automatic logic [HALF_W-1:0] rotl24(input logic [HALF_W-1:0] x,
                                                input logic [ROT_W-1:0] s);
      logic [2*HALF_W-1:0] d;
      d = {x, x} << s;
      rotl24 = d[2*HALF_W-1:HALF_W];
   endfunction

   function automatic logic [HALF_W-1:0] rotr24(input logic [HALF_W-1:0] x,
                                                input logic [ROT_W-1:0] s);
      logic [2*HALF_W-1:0] d;
      d = {x, x} >> s;
      rotr24 = d[HALF_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== design/feistel_48bit_block_cipher_tables_top.sv =====
// Top level of the 48-bit Feistel block cipher with loadable tables.
// A table-load beat returns nothing. An encrypt or decrypt beat runs ROUNDS
// rounds, each a sequence of phases (for encryption: key and rotation read,
// S-box read, substitution and permutation read, mix-map read, fold), set by
// the chain of dependent single-port table reads in a round, and ends in a
// result beat; the input is taken again in the cycle after the last round.
// The result waits in an output register, and the last round holds only if
// the previous result has still not been taken. Tables hold garbage until
// loaded.
`default_nettype none
module feistel_48bit_block_cipher_tables_top
   import fbc_pkg::*;
#(
   parameter int ROUNDS      = ROUNDS_DEF,
   parameter int PERM_TABLES = PERM_TABLES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [2:0]         req_table_select,
   input  wire logic [11:0]        req_table_index,
   input  wire logic [7:0]         req_table_value,
   input  wire logic [BLOCK_W-1:0] req_block_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [BLOCK_W-1:0]      rsp_block_out,
   output logic                    rsp_parity_bit,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   fbc_cmd_type                 cmd;
   logic [$clog2(ROUNDS)-1:0]   rnd;
   logic [TBL_W-1:0]            tbl;
   logic [SEL_W-1:0]            mix_sel_ff;

   // mix selector register
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mix_sel_ff <= SEL_RESET;
      end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         mix_sel_ff <= pwdata[SEL_W-1:0];
      end
   end
   assign prdata = (paddr[2] == 1'b0) ? {{(32-SEL_W){1'b0}}, mix_sel_ff} : '0;

   fbc_ctrl #(.ROUNDS(ROUNDS), .PERM_TABLES(PERM_TABLES)) u_ctrl (
      .clock, .reset,
      .req_valid, .req_ready, .req_opcode,
      .rsp_valid, .rsp_ready,
      .cmd, .rnd, .tbl);

   fbc_dpath #(.ROUNDS(ROUNDS)) u_dpath (
      .clock, .cmd, .rnd, .tbl,
      .ld_select(req_table_select), .ld_index(req_table_index),
      .ld_value(req_table_value), .block_in(req_block_in),
      .mix_sel(mix_sel_ff),
      .block_out(rsp_block_out), .parity_bit(rsp_parity_bit));

endmodule
`default_nettype wire

// ===== design/fbc_ram.sv =====
// Generic one-write one-read RAM with registered read data.
`default_nettype none
module fbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== design/fbc_ctrl.sv =====
// Round sequencer: accepts beats, steps five phases per round, owns the result valid.
`default_nettype none
module fbc_ctrl
   import fbc_pkg::*;
#(
   parameter int ROUNDS      = ROUNDS_DEF,
   parameter int PERM_TABLES = PERM_TABLES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_opcode,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output fbc_cmd_type                    cmd,
   output logic [$clog2(ROUNDS)-1:0]      rnd,
   output logic [TBL_W-1:0]               tbl
);

   localparam int RW     = $clog2(ROUNDS);
   localparam int DEC_Y0 = (((ROUNDS-1) % PERM_TABLES) == 0) ? PERM_TABLES
                                                             : ((ROUNDS-1) % PERM_TABLES);
   localparam logic [RW-1:0]    LAST_RND = RW'(ROUNDS-1);
   localparam logic [TBL_W-1:0] DEC_T0   = TBL_W'(DEC_Y0-1);
   localparam logic [TBL_W-1:0] TBL_TOP  = TBL_W'(PERM_TABLES-1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } fbc_state_type;

   fbc_state_type      state_ff, state_in;
   logic [PHASES-1:0]  phase_ff, phase_in;
   logic [RW-1:0]      rnd_ff, rnd_in;
   logic [TBL_W-1:0]   tbl_ff, tbl_in;
   logic               dec_ff, dec_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept, is_crypt, last, step, finish;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_crypt  = (req_opcode == OP_ENC) || (req_opcode == OP_DEC);
   assign last      = (rnd_ff == LAST_RND);
   // hold the final fold while the previous result beat is still waiting
   assign step      = (state_ff == ST_RUN) &&
                      !(phase_ff[PH_FOLD] && last && rsp_valid_ff && !rsp_ready);
   assign finish    = step && phase_ff[PH_FOLD] && last;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rnd_in       = rnd_ff;
      tbl_in       = tbl_ff;
      dec_in       = dec_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_crypt) begin
               state_in = ST_RUN;
               phase_in = PHASES'(1) << PH_KEY;
               rnd_in   = '0;
               dec_in   = (req_opcode == OP_DEC);
               tbl_in   = (req_opcode == OP_DEC) ? DEC_T0 : '0;
            end
         end
         ST_RUN: begin
            if (step) begin
               phase_in = {phase_ff[PHASES-2:0], phase_ff[PHASES-1]};
               if (phase_ff[PH_FOLD]) begin
                  if (last) begin
                     state_in     = ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end else begin
                     rnd_in = rnd_ff + RW'(1);
                     if (dec_ff) begin
                        tbl_in = (tbl_ff == '0) ? TBL_TOP : tbl_ff - TBL_W'(1);
                     end else begin
                        tbl_in = (tbl_ff == TBL_TOP) ? '0 : tbl_ff + TBL_W'(1);
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         rnd_ff       <= '0;
         tbl_ff       <= '0;
         dec_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rnd_ff       <= rnd_in;
         tbl_ff       <= tbl_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // commands
   assign cmd.load    = accept && (req_opcode == OP_LOAD);
   assign cmd.start   = accept && is_crypt;
   assign cmd.decrypt = dec_ff;
   assign cmd.step    = step;
   assign cmd.last    = last;
   assign cmd.phase   = phase_ff;
   assign rnd         = rnd_ff;
   assign tbl         = tbl_ff;
   assign rsp_valid   = rsp_valid_ff;

   // checks
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> $onehot(phase_ff))
      else $error("round phase not one-hot");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (accept && is_crypt) |=> (state_ff == ST_RUN) && phase_ff[PH_KEY] && (rnd_ff == '0))
      else $error("block start did not enter round zero");
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= LAST_RND)
      else $error("round counter out of range");
   a_finish: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished block gave no result beat");

endmodule
`default_nettype wire

// ===== design/fbc_dpath.sv =====
// Cipher datapath: table RAMs, half registers, round arithmetic and result register.
`default_nettype none
module fbc_dpath
   import fbc_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEF
) (
   input  wire logic                         clock,
   input  wire fbc_cmd_type                  cmd,
   input  wire logic [$clog2(ROUNDS)-1:0]    rnd,
   input  wire logic [TBL_W-1:0]             tbl,
   input  wire logic [2:0]                   ld_select,
   input  wire logic [11:0]                  ld_index,
   input  wire logic [7:0]                   ld_value,
   input  wire logic [BLOCK_W-1:0]           block_in,
   input  wire logic [SEL_W-1:0]             mix_sel,
   output logic      [BLOCK_W-1:0]           block_out,
   output logic                              parity_bit
);

   localparam int RW        = $clog2(ROUNDS);
   localparam int KEY_DEPTH = 3 * ROUNDS;
   localparam int PROD_W    = 22;
   localparam logic [RW-1:0] LAST_RND = RW'(ROUNDS-1);

   fbc_half_type l_ff, r_ff, t_ff;
   logic         par_ff;
   logic [BLOCK_W-1:0] res_block_ff;
   logic               res_par_ff;

   logic [7:0] k1_q [3];
   logic [7:0] k2_q [3];
   logic [7:0] sb_q [3];
   logic [7:0] isb_q [3];
   logic [7:0] pm_q [3];
   logic [7:0] mm_q [3];
   logic [ROT_W-1:0] rot_q;

   fbc_half_type k1, k2, wh, w, a, sb_addr, rn, xs, xr, ln, pm_addr, tn, tot, nr;
   logic [ROT_W-1:0] amt;
   logic [RW-1:0]    kb, k1_addr, k2_addr, rot_addr;
   logic             ph_key, ph_sbox, ph_subst, ph_mix, ph_fold, dec;
   logic             perm_re, mm_re;

   // load decode
   logic [PROD_W-1:0] key_prod;
   logic [10:0]       key_round;
   logic [11:0]       three_r;
   logic [1:0]        key_lane;
   logic              key_ok, byte_ok, rot_ok;
   logic              we_perm, we_mix, we_sbox, we_isbx, we_k1, we_k2, we_rot;

   assign key_prod  = PROD_W'(ld_index) * PROD_W'(KEY_RECIP);
   assign key_round = key_prod[PROD_W-1:KEY_SHIFT];
   assign three_r   = 12'(key_round) * 12'd3;
   assign key_lane  = 2'(ld_index - three_r);
   assign key_ok    = ld_index < 12'(KEY_DEPTH);
   assign byte_ok   = (ld_index[11:8] == 4'd0);
   assign rot_ok    = ld_index < 12'(ROUNDS);

   assign we_perm = cmd.load && (ld_select == TS_PERM);
   assign we_mix  = cmd.load && (ld_select == TS_MIX)  && byte_ok;
   assign we_sbox = cmd.load && (ld_select == TS_SBOX) && byte_ok;
   assign we_isbx = cmd.load && (ld_select == TS_ISBX) && byte_ok;
   assign we_k1   = cmd.load && (ld_select == TS_KEY1) && key_ok;
   assign we_k2   = cmd.load && (ld_select == TS_KEY2) && key_ok;
   assign we_rot  = cmd.load && (ld_select == TS_ROT)  && rot_ok;

   // phase decode
   assign dec      = cmd.decrypt;
   assign ph_key   = cmd.step && cmd.phase[PH_KEY];
   assign ph_sbox  = cmd.step && cmd.phase[PH_SBOX];
   assign ph_subst = cmd.step && cmd.phase[PH_SUBST];
   assign ph_mix   = cmd.step && cmd.phase[PH_MIX];
   assign ph_fold  = cmd.step && cmd.phase[PH_FOLD];

   assign kb       = LAST_RND - rnd;
   assign k1_addr  = dec ? kb : rnd;
   assign k2_addr  = dec ? rnd : kb;
   assign rot_addr = dec ? kb : rnd;
   assign amt      = rot_amt(rot_q);
   assign perm_re  = (dec && ph_key) || (!dec && ph_subst);
   assign mm_re    = (dec && ph_sbox) || (!dec && ph_mix);

   // round arithmetic
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         k1[j] = k1_q[j];
         k2[j] = k2_q[j];
      end
      // encrypt: whiten and rotate left
      wh[0] = r_ff[0] + ~k2[0];
      wh[1] = r_ff[1] ^ ~k2[1];
      wh[2] = r_ff[2] + ~k2[2];
      w     = rotl24(wh, amt);
      // decrypt: key before substitution
      a[0]  = l_ff[0] ^ k1[0];
      a[1]  = l_ff[1] + k1[1];
      a[2]  = l_ff[2] ^ k1[2];
      sb_addr = dec ? a : w;
      // encrypt: substitution then key
      rn[0] = sb_q[0] ^ k1[0];
      rn[1] = isb_q[1] - k1[1];
      rn[2] = sb_q[2] ^ k1[2];
      // decrypt: substitution, rotate right, un-whiten
      xs[0] = isb_q[0];
      xs[1] = sb_q[1];
      xs[2] = isb_q[2];
      xr    = rotr24(xs, amt);
      ln[0] = xr[0] - ~k2[0];
      ln[1] = xr[1] ^ ~k2[1];
      ln[2] = xr[2] - ~k2[2];
      pm_addr = dec ? r_ff : rn;
      // mix sums from the permutation bytes
      for (int row = 0; row < 3; row++) begin
         logic [7:0] b [3];
         for (int c = 0; c < 3; c++) begin
            logic [1:0] v;
            v = mix_sel[(row*3 + c)*2 +: 2];
            unique case (v)
               2'd1:    b[c] = pm_q[1];
               2'd2:    b[c] = pm_q[2];
               default: b[c] = pm_q[0];
            endcase
         end
         tn[row] = (b[0] + b[1]) ^ b[2];
      end
      // fold into the other half
      for (int j = 0; j < 3; j++) begin
         tot[j] = t_ff[j] + mm_q[j];
      end
      if (dec) begin
         nr[0] = l_ff[0] + tot[0];
         nr[2] = l_ff[2] + tot[2];
      end else begin
         nr[0] = l_ff[0] - tot[0];
         nr[2] = l_ff[2] - tot[2];
      end
      nr[1] = l_ff[1] ^ tot[1];
   end

   // half registers and parity
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         l_ff   <= block_in[BLOCK_W-1:HALF_W];
         r_ff   <= block_in[HALF_W-1:0];
         par_ff <= 1'b0;
      end else begin
         if (ph_sbox && !dec) begin
            par_ff <= par_ff ^ r_ff[0][0] ^ r_ff[1][0] ^ r_ff[2][0];
         end
         if (ph_subst) begin
            if (dec) begin
               l_ff   <= ln;
               par_ff <= par_ff ^ ln[0][0] ^ ln[1][0] ^ ln[2][0];
            end else begin
               r_ff <= rn;
            end
         end
         if ((dec && ph_sbox) || (!dec && ph_mix)) begin
            t_ff <= tn;
         end
         if (ph_fold) begin
            l_ff <= r_ff;
            r_ff <= nr;
            if (cmd.last) begin
               res_block_ff <= {r_ff, l_ff};
               res_par_ff   <= par_ff;
            end
         end
      end
   end

   assign block_out  = res_block_ff;
   assign parity_bit = res_par_ff;

   // byte-wide tables per lane: key tables hold one key byte each, others a full copy
   for (genvar j = 0; j < 3; j++) begin : g_lane
      fbc_ram #(.WIDTH(8), .DEPTH(ROUNDS)) u_k1 (
         .clock, .we(we_k1 && (key_lane == 2'(j))), .waddr(key_round[RW-1:0]),
         .wdata(ld_value), .re(ph_key), .raddr(k1_addr), .rdata(k1_q[j]));
      fbc_ram #(.WIDTH(8), .DEPTH(ROUNDS)) u_k2 (
         .clock, .we(we_k2 && (key_lane == 2'(j))), .waddr(key_round[RW-1:0]),
         .wdata(ld_value), .re(ph_key), .raddr(k2_addr), .rdata(k2_q[j]));
      fbc_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_sbox (
         .clock, .we(we_sbox), .waddr(ld_index[7:0]), .wdata(ld_value),
         .re(ph_sbox), .raddr(sb_addr[j]), .rdata(sb_q[j]));
      fbc_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_isbx (
         .clock, .we(we_isbx), .waddr(ld_index[7:0]), .wdata(ld_value),
         .re(ph_sbox), .raddr(sb_addr[j]), .rdata(isb_q[j]));
      fbc_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm (
         .clock, .we(we_perm), .waddr(ld_index), .wdata(ld_value),
         .re(perm_re), .raddr({tbl, pm_addr[j]}), .rdata(pm_q[j]));
      fbc_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_mix (
         .clock, .we(we_mix), .waddr(ld_index[7:0]), .wdata(ld_value),
         .re(mm_re), .raddr(tn[j]), .rdata(mm_q[j]));
   end

   fbc_ram #(.WIDTH(ROT_W), .DEPTH(ROUNDS)) u_rot (
      .clock, .we(we_rot), .waddr(ld_index[RW-1:0]), .wdata(ld_value[ROT_W-1:0]),
      .re(ph_key), .raddr(rot_addr), .rdata(rot_q));

endmodule
`default_nettype wire
